/* src/svc_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// Steering velocity compensator package
// Shared types, constants and the Taylor divisor tables.
// ============================================================================
package svc_pkg;

    localparam int unsigned AngleW    = 16;
    localparam int unsigned DiffW     = 17;
    localparam int unsigned VelW      = 32;
    localparam int unsigned CorrW     = 35;
    localparam int unsigned WheelW    = 16;
    localparam int unsigned ThrW      = 15;
    localparam int unsigned DataW     = 96;
    localparam int unsigned CfgIdxW   = 2;
    localparam int unsigned CfgDataW  = 16;

    localparam logic [WheelW-1:0] WheelbaseReset = 16'd2048;
    localparam logic [ThrW-1:0]   ThresholdReset = 15'd41;

    localparam logic [CfgIdxW-1:0] CfgWheelbase = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd1;

    localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
    localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
    localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
    localparam logic [31:0]        PiQ29     = 32'd1686629713;
    localparam logic signed [34:0] OneQ30    = 35'sd1073741824;

    localparam logic [2:0] LastTerm = 3'd5;
    localparam logic [5:0] DivLast  = 6'd33;

    typedef enum logic [3:0] {
        L_IDLE, L_RED, L_FOLD, L_SQ, L_SQ_DONE, L_TMUL, L_TREC,
        L_PMUL, L_VMUL, L_VDIV, L_DONE
    } t_lane_state;

    typedef struct packed {
        logic start;
        logic apply;
    } t_lane_req;

    // The Taylor divisor of term k is 2^pre times an odd factor. The odd part
    // is divided by multiplying with its rounded-up reciprocal and shifting
    // right by post, which is exact for dividends below 2^31.
    function automatic logic [5:0] term_pre(input logic [2:0] k);
        logic [5:0] r;
        unique case (k)
            3'd2:    r = 6'd2;
            3'd4:    r = 6'd3;
            default: r = 6'd1;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] term_recip(input logic [2:0] k);
        logic [31:0] r;
        unique case (k)
            3'd2:    r = 32'd3435973837;
            3'd3:    r = 32'd3272356036;
            3'd4:    r = 32'd3817748708;
            3'd5:    r = 32'd2498890064;
            default: r = 32'd2863311531;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] term_post(input logic [2:0] k);
        logic [5:0] r;
        unique case (k)
            3'd2:    r = 6'd34;
            3'd3:    r = 6'd36;
            3'd4:    r = 6'd35;
            3'd5:    r = 6'd37;
            default: r = 6'd33;
        endcase
        return r;
    endfunction

endpackage

/* src/steering_velocity_compensator_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// Steering velocity compensator core
// Stores measured steering angles and corrects drive command velocities.
// ============================================================================
// A measured-angle transaction (tuser 0) updates the stored angles and
// produces no output. A drive command (tuser 1) is processed by two lanes in
// parallel, one per side; each lane runs a shared multiplier that forms each
// Taylor term as a product followed by a reciprocal multiplication for the
// divisor, and a restoring divider that yields one quotient bit per cycle for
// the final 34-bit division by the angle error. The output transaction becomes
// valid once both lanes are done and the output register is free, and later
// when the angle error must first be reduced by one to three full turns. A side
// whose error is within the threshold finishes at once. The input accepts
// no new transaction until the result has moved into the output register,
// which then waits independently for the sink.
module steering_velocity_compensator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // left_angle[15:0], right_angle[31:16], left_velocity[63:32],
    // right_velocity[95:64]
    input  logic [svc_pkg::DataW-1:0]         i_s_axis_tdata,
    // op[0]
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // left_velocity_out[31:0], right_velocity_out[63:32],
    // left_steering_out[79:64], right_steering_out[95:80]
    output logic [svc_pkg::DataW-1:0]         o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [svc_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [svc_pkg::CfgDataW-1:0]      i_cfg_data
);

    logic [svc_pkg::WheelW-1:0]         r_wheelbase;
    logic [svc_pkg::ThrW-1:0]           r_threshold;
    logic signed [svc_pkg::AngleW-1:0]  r_meas_l, r_meas_r;
    logic                               r_busy;
    logic signed [svc_pkg::VelW-1:0]    r_vel_l, r_vel_r;
    logic [svc_pkg::AngleW-1:0]         r_ang_l, r_ang_r;

    logic                               accept, load, free;
    logic signed [svc_pkg::AngleW-1:0]  in_l, in_r;
    logic signed [svc_pkg::DiffW-1:0]   diff_l, diff_r;
    logic [svc_pkg::DiffW-1:0]          mag_l, mag_r;
    svc_pkg::t_lane_req                 req_l, req_r;
    logic                               done_l, done_r;
    logic signed [svc_pkg::CorrW-1:0]   corr_l, corr_r;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_busy;
    assign accept          = i_s_axis_tvalid && !r_busy;

    assign in_l   = i_s_axis_tdata[15:0];
    assign in_r   = i_s_axis_tdata[31:16];
    assign diff_l = 17'(in_l) - 17'(r_meas_l);
    assign diff_r = 17'(in_r) - 17'(r_meas_r);
    assign mag_l  = diff_l[16] ? 17'(-diff_l) : 17'(diff_l);
    assign mag_r  = diff_r[16] ? 17'(-diff_r) : 17'(diff_r);

    assign req_l.start = accept && i_s_axis_tuser;
    assign req_l.apply = mag_l > 17'(r_threshold);
    assign req_r.start = accept && i_s_axis_tuser;
    assign req_r.apply = mag_r > 17'(r_threshold);

    assign load = done_l && done_r && free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheelbase <= svc_pkg::WheelbaseReset;
            r_threshold <= svc_pkg::ThresholdReset;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == svc_pkg::CfgWheelbase) begin
                r_wheelbase <= i_cfg_data;
            end else if (i_cfg_index == svc_pkg::CfgThreshold) begin
                r_threshold <= i_cfg_data[svc_pkg::ThrW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_l <= '0;
            r_meas_r <= '0;
            r_busy   <= 1'b0;
        end else begin
            if (accept && !i_s_axis_tuser) begin
                r_meas_l <= in_l;
                r_meas_r <= in_r;
            end
            if (accept && i_s_axis_tuser) begin
                r_busy <= 1'b1;
            end else if (load) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_s_axis_tuser) begin
            r_ang_l <= i_s_axis_tdata[15:0];
            r_ang_r <= i_s_axis_tdata[31:16];
            r_vel_l <= i_s_axis_tdata[63:32];
            r_vel_r <= i_s_axis_tdata[95:64];
        end
    end

    svc_lane u_lane_l (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_l),
        .i_ack       (load),
        .i_diff      (diff_l),
        .i_wheelbase (r_wheelbase),
        .o_done      (done_l),
        .o_corr      (corr_l)
    );

    svc_lane u_lane_r (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_r),
        .i_ack       (load),
        .i_diff      (diff_r),
        .i_wheelbase (r_wheelbase),
        .o_done      (done_r),
        .o_corr      (corr_r)
    );

    svc_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_left_vel    (r_vel_l),
        .i_right_vel   (r_vel_r),
        .i_left_corr   (corr_l),
        .i_right_corr  (corr_r),
        .i_left_angle  (r_ang_l),
        .i_right_angle (r_ang_r),
        .o_free        (free),
        .o_tvalid      (o_m_axis_tvalid),
        .i_tready      (i_m_axis_tready),
        .o_tdata       (o_m_axis_tdata)
    );

endmodule

/* src/svc_lane.sv */
`timescale 1ns / 1ps
// ============================================================================
// Compensator lane
// Computes the signed velocity correction for one side with a shared
// multiplier, reciprocal multiplication for the Taylor divisors and a
// one-bit-per-cycle restoring divider for the division by the angle error.
// ============================================================================
module svc_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  svc_pkg::t_lane_req                   i_req,
    input  logic                                 i_ack,
    input  logic signed [svc_pkg::DiffW-1:0]     i_diff,
    input  logic [svc_pkg::WheelW-1:0]           i_wheelbase,
    output logic                                 o_done,
    output logic signed [svc_pkg::CorrW-1:0]     o_corr
);

    localparam int unsigned CorrWL = svc_pkg::CorrW;

    svc_pkg::t_lane_state r_state, n_state;

    logic signed [35:0] r_a;
    logic               r_neg;
    logic [30:0]        r_x;
    logic [31:0]        r_x2;
    logic [31:0]        r_t;
    logic signed [34:0] r_s;
    logic [2:0]         r_k;
    logic [63:0]        r_prod;
    logic [15:0]        r_rem;
    logic [33:0]        r_quo;
    logic [15:0]        r_div;
    logic [5:0]         r_cnt;
    logic [15:0]        r_mag;
    logic signed [CorrWL-1:0] r_corr;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_out;
    logic [31:0]        q_rec;
    logic [16:0]        rem_sh;
    logic               ge;
    logic [15:0]        rem_nx;
    logic [33:0]        q_next;
    logic signed [35:0] a_fold;
    logic [35:0]        x_abs;
    logic [31:0]        s_cl;
    logic [16:0]        d_abs;

    assign d_abs = i_diff[16] ? 17'(-i_diff) : 17'(i_diff);

    always_comb begin
        if (r_a > svc_pkg::HalfPiQ30) begin
            a_fold = svc_pkg::PiQ30 - r_a;
        end else if (r_a < -svc_pkg::HalfPiQ30) begin
            a_fold = -svc_pkg::PiQ30 - r_a;
        end else begin
            a_fold = r_a;
        end
        x_abs = a_fold[35] ? 36'(-a_fold) : 36'(a_fold);
    end

    always_comb begin
        if (r_s < 0) begin
            s_cl = 32'd0;
        end else if (r_s > svc_pkg::OneQ30) begin
            s_cl = 32'(svc_pkg::OneQ30);
        end else begin
            s_cl = r_s[31:0];
        end
    end

    always_comb begin
        unique case (r_state)
            svc_pkg::L_SQ: begin
                mul_a = {1'b0, r_x};
                mul_b = {1'b0, r_x};
            end
            svc_pkg::L_TMUL: begin
                mul_a = r_t;
                mul_b = r_x2;
            end
            svc_pkg::L_TREC: begin
                mul_a = 32'(r_quo >> svc_pkg::term_pre(r_k));
                mul_b = svc_pkg::term_recip(r_k);
            end
            svc_pkg::L_PMUL: begin
                mul_a = s_cl;
                mul_b = {16'd0, i_wheelbase};
            end
            svc_pkg::L_VMUL: begin
                mul_a = r_prod[45:14];
                mul_b = svc_pkg::PiQ29;
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        mul_out = 64'(mul_a) * 64'(mul_b);
        q_rec   = 32'(mul_out >> svc_pkg::term_post(r_k));
    end

    assign rem_sh = {r_rem, r_quo[33]};
    assign ge     = rem_sh >= {1'b0, r_div};
    assign rem_nx = ge ? 16'(rem_sh - {1'b0, r_div}) : rem_sh[15:0];
    assign q_next = {r_quo[32:0], ge};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            svc_pkg::L_IDLE: begin
                if (i_req.start) begin
                    n_state = i_req.apply ? svc_pkg::L_RED : svc_pkg::L_DONE;
                end
            end
            svc_pkg::L_RED: begin
                if (r_a <= svc_pkg::PiQ30 && r_a >= -svc_pkg::PiQ30) begin
                    n_state = svc_pkg::L_FOLD;
                end
            end
            svc_pkg::L_FOLD:    n_state = svc_pkg::L_SQ;
            svc_pkg::L_SQ:      n_state = svc_pkg::L_SQ_DONE;
            svc_pkg::L_SQ_DONE: n_state = svc_pkg::L_TMUL;
            svc_pkg::L_TMUL:    n_state = svc_pkg::L_TREC;
            svc_pkg::L_TREC: begin
                n_state = (r_k == svc_pkg::LastTerm) ? svc_pkg::L_PMUL
                                                      : svc_pkg::L_TMUL;
            end
            svc_pkg::L_PMUL: n_state = svc_pkg::L_VMUL;
            svc_pkg::L_VMUL: n_state = svc_pkg::L_VDIV;
            svc_pkg::L_VDIV: begin
                if (r_cnt == svc_pkg::DivLast) begin
                    n_state = svc_pkg::L_DONE;
                end
            end
            svc_pkg::L_DONE: begin
                if (i_ack) begin
                    n_state = svc_pkg::L_IDLE;
                end
            end
            default: n_state = svc_pkg::L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svc_pkg::L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            svc_pkg::L_IDLE: begin
                r_a    <= 36'(i_diff) <<< 18;
                r_mag  <= d_abs[15:0];
                r_corr <= '0;
            end
            svc_pkg::L_RED: begin
                if (r_a > svc_pkg::PiQ30) begin
                    r_a <= r_a - svc_pkg::TwoPiQ30;
                end else if (r_a < -svc_pkg::PiQ30) begin
                    r_a <= r_a + svc_pkg::TwoPiQ30;
                end
            end
            svc_pkg::L_FOLD: begin
                r_neg <= a_fold[35];
                r_x   <= x_abs[30:0];
                r_t   <= {1'b0, x_abs[30:0]};
                r_s   <= 35'(x_abs[30:0]);
                r_k   <= 3'd1;
            end
            svc_pkg::L_SQ: begin
                r_prod <= mul_out;
            end
            svc_pkg::L_SQ_DONE: begin
                r_x2 <= r_prod[61:30];
            end
            svc_pkg::L_TMUL: begin
                r_quo <= mul_out[63:30];
            end
            svc_pkg::L_TREC: begin
                r_t <= q_rec;
                r_k <= r_k + 3'd1;
                if (r_k[0]) begin
                    r_s <= r_s - $signed({3'b0, q_rec});
                end else begin
                    r_s <= r_s + $signed({3'b0, q_rec});
                end
            end
            svc_pkg::L_PMUL: begin
                r_prod <= mul_out;
            end
            svc_pkg::L_VMUL: begin
                r_quo <= mul_out[63:30];
                r_rem <= '0;
                r_div <= r_mag;
                r_cnt <= '0;
            end
            svc_pkg::L_VDIV: begin
                r_rem <= rem_nx;
                r_quo <= q_next;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == svc_pkg::DivLast) begin
                    r_corr <= r_neg ? -$signed({1'b0, q_next})
                                    : $signed({1'b0, q_next});
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == svc_pkg::L_DONE);
    assign o_corr = r_corr;

endmodule

/* src/svc_merge.sv */
`timescale 1ns / 1ps
// ============================================================================
// Compensator merge stage
// Adds the left correction to and subtracts the right from the velocities
// with saturation and holds the result transaction in the output register.
// ============================================================================
module svc_merge (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic signed [svc_pkg::VelW-1:0]      i_left_vel,
    input  logic signed [svc_pkg::VelW-1:0]      i_right_vel,
    input  logic signed [svc_pkg::CorrW-1:0]     i_left_corr,
    input  logic signed [svc_pkg::CorrW-1:0]     i_right_corr,
    input  logic [svc_pkg::AngleW-1:0]           i_left_angle,
    input  logic [svc_pkg::AngleW-1:0]           i_right_angle,
    output logic                                 o_free,
    output logic                                 o_tvalid,
    input  logic                                 i_tready,
    output logic [svc_pkg::DataW-1:0]            o_tdata
);

    logic                       r_valid;
    logic [svc_pkg::DataW-1:0]  r_data;
    logic signed [35:0]         sum_l, sum_r;
    logic [31:0]                sat_l, sat_r;

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign sum_l = 36'(i_left_vel) + 36'(i_left_corr);
    assign sum_r = 36'(i_right_vel) - 36'(i_right_corr);
    assign sat_l = sat32(sum_l);
    assign sat_r = sat32(sum_r);

    assign o_free = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= {i_right_angle, i_left_angle, sat_r, sat_l};
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;

endmodule

/* src/svc_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// Compensator port checker
// Concurrent checks on the top-level ports, bound to the core.
// ============================================================================
module svc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          i_s_axis_tuser,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [svc_pkg::DataW-1:0]     o_m_axis_tdata,
    input logic                          o_cfg_ready
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("Output valid or input stall after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("Output transaction changed while stalled.");

    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser) |=> !o_s_axis_tready)
        else $error("Input ready after a drive command was accepted.");

    a_meas_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser) |=>
            (o_s_axis_tready && o_cfg_ready))
        else $error("Angle update stalled the input.");

endmodule

bind steering_velocity_compensator_core svc_checker u_svc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_cfg_ready     (o_cfg_ready)
);

/* test/steering_velocity_compensator_core_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// Steering velocity compensator core testbench
// Drives measured-angle and drive-command transactions with random gaps and
// output stalls, predicts each corrected command in a scoreboard and checks
// every output transaction field by field across several register settings.
// ============================================================================
module steering_velocity_compensator_core_tb;

    localparam int unsigned IdleLimit = 20000;
    localparam int unsigned Latency   = 300;

    typedef struct packed {
        logic signed [31:0] right_vel;
        logic signed [31:0] left_vel;
        logic signed [15:0] right_steer;
        logic signed [15:0] left_steer;
    } t_command_result;

    class compensation_scoreboard;
        logic [svc_pkg::WheelW-1:0] wheelbase;
        logic [svc_pkg::ThrW-1:0]   threshold;
        logic signed [15:0] meas_left;
        logic signed [15:0] meas_right;
        t_command_result    pending[$];
        int                 errors;

        function new();
            wheelbase = svc_pkg::WheelbaseReset;
            threshold = svc_pkg::ThresholdReset;
            meas_left = '0;
            meas_right = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [svc_pkg::CfgIdxW-1:0] idx,
                                logic [svc_pkg::CfgDataW-1:0] value);
            if (idx == svc_pkg::CfgWheelbase) begin
                wheelbase = value;
            end else if (idx == svc_pkg::CfgThreshold) begin
                threshold = value[svc_pkg::ThrW-1:0];
            end
        endfunction

        function longint steer_correction(int err);
            longint ang;
            longint sum;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned mag;
            longint unsigned prod;
            longint unsigned v;
            bit neg;
            ang = longint'(err) * 262144;
            while (ang > 64'sd3373259426) ang -= 64'sd6746518852;
            while (ang < -64'sd3373259426) ang += 64'sd6746518852;
            if (ang > 64'sd1686629713) begin
                ang = 64'sd3373259426 - ang;
            end else if (ang < -64'sd1686629713) begin
                ang = -64'sd3373259426 - ang;
            end
            neg = ang < 0;
            x = neg ? -ang : ang;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int k = 1; k <= 5; k++) begin
                term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) sum -= term;
                else sum += term;
            end
            if (sum < 0) sum = 0;
            if (sum > 64'sd1073741824) sum = 64'sd1073741824;
            mag = err < 0 ? -err : err;
            prod = (longint'(sum) * wheelbase) >> 14;
            v = ((prod * 64'd1686629713) / mag) >> 30;
            return neg ? -longint'(v) : longint'(v);
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void note_input(logic op, logic [svc_pkg::DataW-1:0] data);
            logic signed [15:0] la;
            logic signed [15:0] ra;
            longint lv;
            longint rv;
            int dl;
            int dr;
            t_command_result res;
            la = data[15:0];
            ra = data[31:16];
            if (!op) begin
                meas_left = la;
                meas_right = ra;
                return;
            end
            lv = $signed(data[63:32]);
            rv = $signed(data[95:64]);
            dl = int'(la) - int'(meas_left);
            dr = int'(ra) - int'(meas_right);
            if ((dl < 0 ? -dl : dl) > int'(threshold)) lv = clamp32(lv + steer_correction(dl));
            if ((dr < 0 ? -dr : dr) > int'(threshold)) rv = clamp32(rv - steer_correction(dr));
            res.left_vel = lv[31:0];
            res.right_vel = rv[31:0];
            res.left_steer = la;
            res.right_steer = ra;
            pending.push_back(res);
        endfunction

        function void check_result(logic [svc_pkg::DataW-1:0] data);
            t_command_result exp_r;
            t_command_result act;
            act.left_vel = data[31:0];
            act.right_vel = data[63:32];
            act.left_steer = data[79:64];
            act.right_steer = data[95:80];
            if (pending.size() == 0) begin
                $display("%0t: unexpected output transaction %h", $time, data);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (act.left_vel !== exp_r.left_vel) begin
                $display("%0t: left velocity expected %0d actual %0d", $time,
                         exp_r.left_vel, act.left_vel);
                errors++;
            end
            if (act.right_vel !== exp_r.right_vel) begin
                $display("%0t: right velocity expected %0d actual %0d", $time,
                         exp_r.right_vel, act.right_vel);
                errors++;
            end
            if (act.left_steer !== exp_r.left_steer) begin
                $display("%0t: left steering expected %0d actual %0d", $time,
                         exp_r.left_steer, act.left_steer);
                errors++;
            end
            if (act.right_steer !== exp_r.right_steer) begin
                $display("%0t: right steering expected %0d actual %0d", $time,
                         exp_r.right_steer, act.right_steer);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [svc_pkg::DataW-1:0]     s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [svc_pkg::DataW-1:0]     m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [svc_pkg::CfgIdxW-1:0]   cfg_index;
    logic [svc_pkg::CfgDataW-1:0]  cfg_data;

    compensation_scoreboard board;
    int unsigned idle_cycles;
    int unsigned burst_left;
    int unsigned stall_mode;

    steering_velocity_compensator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) board.check_result(m_tdata);
        if (i_rst_n && ((m_tvalid && m_tready) || (s_tvalid && s_tready)
                || (cfg_valid && cfg_ready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > IdleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The sink cycles through open, random and heavily stalled patterns.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [svc_pkg::CfgIdxW-1:0] idx,
                             logic [svc_pkg::CfgDataW-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        board.write_reg(idx, value);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_item(logic op, logic signed [15:0] la, logic signed [15:0] ra,
                             logic [31:0] lv, logic [31:0] rv);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tuser <= op;
        s_tdata <= {rv, lv, ra, la};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        board.note_input(op, {rv, lv, ra, la});
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (Latency) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 200)) - 100);
            2: return 16'($signed($urandom_range(0, 12868)) - 6434);
            default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    function automatic logic [31:0] rand_velocity();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'h7fff_ffff - $urandom_range(0, 70000);
            2: return 32'h8000_0000 + $urandom_range(0, 70000);
            default: return 32'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    initial begin
        logic [svc_pkg::CfgDataW-1:0] wb_set[4];
        logic [svc_pkg::CfgDataW-1:0] thr_set[4];
        board = new();
        idle_cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset registers, threshold edges, extremes, saturation.
        send_item(1'b1, 16'sd0, 16'sd0, 32'h7fff_ffff, 32'h8000_0000);
        send_item(1'b1, 16'sd41, -16'sd41, 32'd0, 32'd0);
        send_item(1'b1, 16'sd42, -16'sd42, 32'd100, 32'd100);
        send_item(1'b0, 16'h7fff, 16'h8000, 32'hffff_ffff, 32'hffff_ffff);
        send_item(1'b1, 16'h8000, 16'h7fff, 32'h7fff_ffff, 32'h8000_0000);
        send_item(1'b1, 16'h7fff, 16'h8000, 32'h8000_0000, 32'h7fff_ffff);
        send_item(1'b0, 16'h8000, 16'h7fff, 32'd0, 32'd0);
        send_item(1'b1, 16'h7fff, 16'h8000, 32'h7fff_ffff, 32'h8000_0000);
        send_item(1'b0, 16'sd0, 16'sd0, 32'd0, 32'd0);
        drain();
        write_reg(svc_pkg::CfgWheelbase, 16'hffff);
        write_reg(svc_pkg::CfgThreshold, 16'd0);
        send_item(1'b1, 16'sd1, -16'sd1, 32'h7fff_0000, 32'h8001_0000);
        send_item(1'b1, -16'sd1, 16'sd1, 32'h8000_0000, 32'h7fff_ffff);
        send_item(1'b1, 16'sd6434, -16'sd6434, 32'd0, 32'd0);
        send_item(1'b1, 16'sd12868, -16'sd12868, 32'd0, 32'd0);
        drain();
        write_reg(svc_pkg::CfgThreshold, 16'h7fff);
        write_reg(svc_pkg::CfgThreshold + 2'd1, 16'h1234);
        write_reg(2'd3, 16'h0);
        send_item(1'b1, 16'h7fff, 16'h8000, 32'd5, 32'd6);
        send_item(1'b0, 16'h8000, 16'h7fff, 32'd0, 32'd0);
        send_item(1'b1, 16'h7fff, 16'h8000, 32'd5, 32'd6);
        drain();

        wb_set = '{16'd0, 16'd2048, 16'hffff, 16'd0};
        thr_set = '{16'd0, 16'd41, 16'd500, 16'h7fff};
        for (int phase = 0; phase < 8; phase++) begin
            if (phase < 4) begin
                write_reg(svc_pkg::CfgWheelbase, wb_set[phase]);
                write_reg(svc_pkg::CfgThreshold, thr_set[phase]);
            end else begin
                write_reg(svc_pkg::CfgWheelbase, 16'($urandom_range(0, 65535)));
                write_reg(svc_pkg::CfgThreshold, 16'($urandom_range(0, 600)));
            end
            for (int n = 0; n < 200; n++) begin
                send_item($urandom_range(0, 2) != 0, rand_angle(), rand_angle(),
                          rand_velocity(), rand_velocity());
            end
            drain();
        end

        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
